>>> src/button_click_long_double_detect_macros.svh
// Assertion macros used by the button gesture detector merge stage.
`ifndef BUTTON_CLICK_LONG_DOUBLE_DETECT_MACROS_SVH
`define BUTTON_CLICK_LONG_DOUBLE_DETECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCLD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCLD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bcld_pkg.sv
// Types and constants of the button click, long and double press detector.
package bcld_pkg;

    localparam logic [7:0] RUN_MAX = 8'd255;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int KIND_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_GAP_TICKS = 2'd2;

    localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd5;
    localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd100;
    localparam logic [15:0] DOUBLE_GAP_TICKS_RST = 16'd25;

    typedef enum logic [KIND_W-1:0] {
        EV_SHORT  = 2'd0,
        EV_LONG   = 2'd1,
        EV_DOUBLE = 2'd2
    } bcld_kind_t;

    typedef enum logic [3:0] {
        GS_WAIT_START = 4'b0001,
        GS_COUNT_LONG = 4'b0010,
        GS_COUNT_GAP  = 4'b0100,
        GS_WAIT_STOP  = 4'b1000
    } bcld_gesture_t;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [15:0] double_gap_ticks;
    } bcld_cfg_t;

    typedef struct packed {
        logic       valid;
        bcld_kind_t kind;
    } bcld_event_t;

endpackage

>>> src/bcld_lane.sv
// Per-button lane: debounce counters, debounced level and gesture state machine.
module bcld_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   tick,
    input  logic                   pressed,
    input  bcld_pkg::bcld_cfg_t    cfg,
    output bcld_pkg::bcld_event_t  lane_event
);
    import bcld_pkg::*;

    logic [7:0]    press_run_reg,   press_run_next;
    logic [7:0]    release_run_reg, release_run_next;
    logic          level_reg,       level_next;
    bcld_gesture_t state_reg,       state_next;
    logic [15:0]   hold_reg,        hold_next;

    always_comb begin
        press_run_next   = press_run_reg;
        release_run_next = release_run_reg;
        level_next       = level_reg;
        state_next       = state_reg;
        hold_next        = hold_reg;
        lane_event.valid = 1'b0;
        lane_event.kind  = EV_SHORT;

        if (pressed) begin
            release_run_next = '0;
            if (press_run_reg != RUN_MAX) begin
                press_run_next = press_run_reg + 8'd1;
            end
            if (press_run_next >= cfg.debounce_ticks) begin
                level_next = 1'b1;
            end
        end else begin
            press_run_next = '0;
            if (release_run_reg != RUN_MAX) begin
                release_run_next = release_run_reg + 8'd1;
            end
            if (release_run_next >= cfg.debounce_ticks) begin
                level_next = 1'b0;
            end
        end

        // States are visited in order, so a state entered here runs this tick too.
        if (state_next == GS_WAIT_START && level_next) begin
            hold_next  = '0;
            state_next = GS_COUNT_LONG;
        end
        if (state_next == GS_COUNT_LONG) begin
            if (level_next) begin
                hold_next = hold_next + 16'd1;
                if (hold_next == cfg.long_press_ticks) begin
                    lane_event.valid = 1'b1;
                    lane_event.kind  = EV_LONG;
                    state_next       = GS_WAIT_STOP;
                end
            end else begin
                hold_next  = '0;
                state_next = GS_COUNT_GAP;
            end
        end
        if (state_next == GS_COUNT_GAP) begin
            if (!level_next) begin
                hold_next = hold_next + 16'd1;
                if (hold_next == cfg.double_gap_ticks) begin
                    lane_event.valid = 1'b1;
                    lane_event.kind  = EV_SHORT;
                    state_next       = GS_WAIT_START;
                end
            end else begin
                lane_event.valid = 1'b1;
                lane_event.kind  = EV_DOUBLE;
                state_next       = GS_WAIT_STOP;
            end
        end
        if (state_next == GS_WAIT_STOP && !level_next) begin
            state_next = GS_WAIT_START;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_run_reg   <= '0;
            release_run_reg <= '0;
            level_reg       <= 1'b0;
            state_reg       <= GS_WAIT_START;
            hold_reg        <= '0;
        end else if (tick) begin
            press_run_reg   <= press_run_next;
            release_run_reg <= release_run_next;
            level_reg       <= level_next;
            state_reg       <= state_next;
            hold_reg        <= hold_next;
        end
    end

endmodule

>>> src/bcld_merge.sv
// Merge stage: hold the events of one tick and send them out in button order.
`include "button_click_long_double_detect_macros.svh"

module bcld_merge #(
    parameter int BUTTON_COUNT = 2,
    parameter int IDX_W        = 1
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     tick,
    input  bcld_pkg::bcld_event_t [BUTTON_COUNT-1:0] lane_event,
    output logic                                     tick_ready,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [IDX_W-1:0]                         out_index,
    output bcld_pkg::bcld_kind_t                     out_kind,
    output logic                                     out_last
);
    import bcld_pkg::*;

    logic [BUTTON_COUNT-1:0] valid_reg, valid_next;
    bcld_kind_t [BUTTON_COUNT-1:0] kind_reg;
    logic [BUTTON_COUNT-1:0] sel_onehot;
    logic                    out_fire;

    assign sel_onehot = valid_reg & (~valid_reg + BUTTON_COUNT'(1));
    assign out_valid  = |valid_reg;
    assign out_last   = (valid_reg & ~sel_onehot) == '0;
    assign out_fire   = out_valid & out_ready;
    assign tick_ready = !out_valid || (out_fire && out_last);

    always_comb begin
        out_index = '0;
        out_kind  = EV_SHORT;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (sel_onehot[i]) begin
                out_index = IDX_W'(i);
                out_kind  = kind_reg[i];
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (tick) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                valid_next[i] = lane_event[i].valid;
            end
        end else if (out_fire) begin
            valid_next = valid_reg & ~sel_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                kind_reg[i] <= lane_event[i].kind;
            end
        end
    end

    `BCLD_ASSERT_NEXT(a_more_after_not_last, aclk, aresetn, out_fire && !out_last && !tick, out_valid, "events lost before the final beat of a tick")
    `BCLD_ASSERT_NOW(a_load_only_when_drained, aclk, aresetn, tick && out_valid, out_fire && out_last, "new tick loaded over pending events")
    `BCLD_ASSERT_NEXT(a_hold_when_stalled, aclk, aresetn, out_valid && !out_ready && !tick, $stable(valid_reg), "pending events changed while stalled")

endmodule

>>> src/button_click_long_double_detect.sv
// Button debounce and gesture detector, top level.
//
// Each input beat is one timer tick with the raw active-low level of every
// button pin. One lane per button debounces the pin and runs the gesture
// state machine; a tick updates all lanes together. The merge stage
// buffers the events of that tick (at most one per button) and sends them
// in button index order, one beat per cycle while m_axis_tready is high,
// tlast on the final one. The next tick is taken when no events are
// pending, or in the cycle that delivers the final beat of the previous
// one. No clearing pass after reset.
// Configuration writes are accepted in every cycle; index 3 is ignored.
module button_click_long_double_detect #(
    parameter int BUTTON_COUNT = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: pin_levels[BUTTON_COUNT-1:0], zero padded
    input  logic [((BUTTON_COUNT+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: button_index, zero padded
    output logic [(((BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1)+7)/8*8-1:0] m_axis_tdata,
    // tuser: event_kind[1:0]
    output logic [bcld_pkg::KIND_W-1:0]         m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bcld_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bcld_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bcld_pkg::*;

    localparam int IDX_W      = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int M_TDATA_W  = ((IDX_W + 7) / 8) * 8;

    bcld_cfg_t                     cfg_reg;
    bcld_event_t [BUTTON_COUNT-1:0] lane_event;
    logic                          tick;
    logic                          tick_ready;
    logic [IDX_W-1:0]              out_index;
    bcld_kind_t                    out_kind;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = tick_ready;
    assign tick          = s_axis_tvalid & tick_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_TICKS_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RST;
            cfg_reg.double_gap_ticks <= DOUBLE_GAP_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS: begin
                    cfg_reg.debounce_ticks <= cfg_data[7:0];
                end
                REG_LONG_PRESS_TICKS: begin
                    cfg_reg.long_press_ticks <= cfg_data;
                end
                REG_DOUBLE_GAP_TICKS: begin
                    cfg_reg.double_gap_ticks <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
        bcld_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tick       (tick),
            .pressed    (~s_axis_tdata[g]),
            .cfg        (cfg_reg),
            .lane_event (lane_event[g])
        );
    end

    bcld_merge #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .IDX_W        (IDX_W)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (tick),
        .lane_event (lane_event),
        .tick_ready (tick_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_index  (out_index),
        .out_kind   (out_kind),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_W'(out_index);
    assign m_axis_tuser = out_kind;

endmodule

>>> bench/tb_button_click_long_double_detect.sv
// Self-checking bench for the button debounce and click, long and double press detector.
`timescale 1ns / 100ps

module tb_button_click_long_double_detect;
    import bcld_pkg::*;

    localparam int LIMIT    = 3_000_000;
    localparam int UNTYPED  = -1;
    localparam int PHASES   = 5;
    localparam int PHASE_TICKS = 260;
    localparam int STALL_CYCLES = 300;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [1:0] BOTH_UP    = 2'b11;
    localparam logic [1:0] BOTH_DOWN  = 2'b00;
    localparam logic [1:0] ONLY0_DOWN = 2'b10;
    localparam logic [1:0] ONLY1_DOWN = 2'b01;

    typedef struct packed {
        logic       button;
        bcld_kind_t kind;
        logic       last;
    } tick_event_t;

    typedef enum logic [1:0] {
        OP_TICKS,
        OP_CONFIG,
        OP_IGNORED
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic [1:0]  pins;
        int          reps;
        int          n_ev;
        tick_event_t ev_a;
        tick_event_t ev_b;
    } dir_row_t;

    localparam tick_event_t NO_EVENT       = '{1'b0, EV_SHORT, 1'b0};
    localparam tick_event_t B0_LONG        = '{1'b0, EV_LONG, 1'b0};
    localparam tick_event_t B1_LONG_LAST   = '{1'b1, EV_LONG, 1'b1};
    localparam tick_event_t B0_SHORT       = '{1'b0, EV_SHORT, 1'b0};
    localparam tick_event_t B0_SHORT_LAST  = '{1'b0, EV_SHORT, 1'b1};
    localparam tick_event_t B1_SHORT_LAST  = '{1'b1, EV_SHORT, 1'b1};
    localparam tick_event_t B1_DOUBLE_LAST = '{1'b1, EV_DOUBLE, 1'b1};

    localparam bcld_cfg_t DIRECTED_CFG [3] = '{
        '{8'd0, 16'd1, 16'd1},
        '{8'd255, 16'd2, 16'd1},
        '{8'd1, 16'hFFFF, 16'd1}
    };

    localparam int ROWS = 26;
    localparam dir_row_t DIRECTED [ROWS] = '{
        '{OP_TICKS, BOTH_UP, 10, 0, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_DOWN, 104, 2, B0_LONG, B1_LONG_LAST},
        '{OP_TICKS, BOTH_UP, 5, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, ONLY0_DOWN, 6, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_UP, 29, 1, B0_SHORT_LAST, NO_EVENT},
        '{OP_TICKS, ONLY1_DOWN, 6, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_UP, 10, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, ONLY1_DOWN, 5, 1, B1_DOUBLE_LAST, NO_EVENT},
        '{OP_TICKS, BOTH_UP, 5, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_DOWN, 1, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_UP, 1, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, ONLY1_DOWN, 1, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, ONLY0_DOWN, 1, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_UP, 5, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_CONFIG, BOTH_UP, 0, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_DOWN, 1, 2, B0_LONG, B1_LONG_LAST},
        '{OP_TICKS, BOTH_UP, 1, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_IGNORED, BOTH_UP, 0, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_DOWN, 1, 2, B0_LONG, B1_LONG_LAST},
        '{OP_TICKS, BOTH_UP, 1, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_CONFIG, BOTH_UP, 0, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_DOWN, 256, 2, B0_LONG, B1_LONG_LAST},
        '{OP_TICKS, BOTH_UP, 255, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_CONFIG, BOTH_UP, 0, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_DOWN, 1, UNTYPED, NO_EVENT, NO_EVENT},
        '{OP_TICKS, BOTH_UP, 1, 2, B0_SHORT, B1_SHORT_LAST}
    };

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    bcld_cfg_t     setting = '{DEBOUNCE_TICKS_RST, LONG_PRESS_TICKS_RST, DOUBLE_GAP_TICKS_RST};
    logic [7:0]    held_count [2] = '{8'd0, 8'd0};
    logic [7:0]    open_count [2] = '{8'd0, 8'd0};
    logic          settled    [2] = '{1'b0, 1'b0};
    bcld_gesture_t gesture    [2] = '{GS_WAIT_START, GS_WAIT_START};
    logic [15:0]   span       [2] = '{16'd0, 16'd0};

    tick_event_t events_due [$];
    tick_event_t want;
    int          errors     = 0;
    int          cycles     = 0;
    int          stall_left = 0;
    bit          no_idle    = 1'b0;
    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;

    always #2 aclk = ~aclk;

    button_click_long_double_detect #(
        .BUTTON_COUNT(2)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    task automatic forecast_tick(input logic [1:0] pins, output tick_event_t evs [2],
                                 output int n);
        bit         fired;
        bit         down;
        bcld_kind_t kind;
        evs[0] = NO_EVENT;
        evs[1] = NO_EVENT;
        n = 0;
        for (int b = 0; b < 2; b++) begin
            down  = !pins[b];
            fired = 1'b0;
            kind  = EV_SHORT;
            if (down) begin
                open_count[b] = 8'd0;
                if (held_count[b] != RUN_MAX) held_count[b]++;
                if (held_count[b] >= setting.debounce_ticks) settled[b] = 1'b1;
            end else begin
                held_count[b] = 8'd0;
                if (open_count[b] != RUN_MAX) open_count[b]++;
                if (open_count[b] >= setting.debounce_ticks) settled[b] = 1'b0;
            end
            if (gesture[b] == GS_WAIT_START && settled[b]) begin
                span[b]    = 16'd0;
                gesture[b] = GS_COUNT_LONG;
            end
            if (gesture[b] == GS_COUNT_LONG) begin
                if (settled[b]) begin
                    span[b]++;
                    if (span[b] == setting.long_press_ticks) begin
                        fired      = 1'b1;
                        kind       = EV_LONG;
                        gesture[b] = GS_WAIT_STOP;
                    end
                end else begin
                    span[b]    = 16'd0;
                    gesture[b] = GS_COUNT_GAP;
                end
            end
            if (gesture[b] == GS_COUNT_GAP) begin
                if (!settled[b]) begin
                    span[b]++;
                    if (span[b] == setting.double_gap_ticks) begin
                        fired      = 1'b1;
                        kind       = EV_SHORT;
                        gesture[b] = GS_WAIT_START;
                    end
                end else begin
                    fired      = 1'b1;
                    kind       = EV_DOUBLE;
                    gesture[b] = GS_WAIT_STOP;
                end
            end
            if (gesture[b] == GS_WAIT_STOP && !settled[b]) gesture[b] = GS_WAIT_START;
            if (fired) begin
                evs[n] = '{1'(b), kind, 1'b0};
                n++;
            end
        end
        if (n > 0) evs[n-1].last = 1'b1;
    endtask

    task automatic drive_tick(input logic [1:0] pins, input int n_typed,
                              input tick_event_t ev_a, input tick_event_t ev_b);
        tick_event_t evs [2];
        int          n;
        while (!no_idle && $urandom_range(0, 99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, pins};
        do @(posedge aclk); while (!s_axis_tready);
        forecast_tick(pins, evs, n);
        if (n_typed != UNTYPED) begin
            n      = n_typed;
            evs[0] = ev_a;
            evs[1] = ev_b;
        end
        for (int i = 0; i < n; i++) events_due.push_back(evs[i]);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE_TICKS:   setting.debounce_ticks   = value[7:0];
            REG_LONG_PRESS_TICKS: setting.long_press_ticks = value;
            REG_DOUBLE_GAP_TICKS: setting.double_gap_ticks = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input bcld_cfg_t cfg);
        write_reg(REG_DEBOUNCE_TICKS, {8'd0, cfg.debounce_ticks});
        write_reg(REG_LONG_PRESS_TICKS, cfg.long_press_ticks);
        write_reg(REG_DOUBLE_GAP_TICKS, cfg.double_gap_ticks);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (events_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (events_due.size() == 0) begin
                $error("event beat with nothing pending: button_index %0d, event_kind %0d",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = events_due.pop_front();
                if (m_axis_tdata !== 8'(want.button)) begin
                    $error("button_index: expected %0d, got %0d", want.button, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        if (hold_req && !hold_done) begin
            stall_left = STALL_CYCLES;
            hold_done  = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int         cfg_next;
        int         d;
        int         l;
        int         g;
        int         goal_left [2];
        bit         goal_down [2];
        logic [1:0] pins;
        bcld_cfg_t  cfg;
        cfg_next     = 0;
        goal_left    = '{0, 0};
        goal_down    = '{1'b0, 1'b0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < ROWS; r++) begin
            case (DIRECTED[r].op)
                OP_TICKS: begin
                    for (int k = 0; k < DIRECTED[r].reps; k++)
                        drive_tick(DIRECTED[r].pins,
                                   (k == DIRECTED[r].reps - 1) ? DIRECTED[r].n_ev : UNTYPED,
                                   DIRECTED[r].ev_a, DIRECTED[r].ev_b);
                end
                OP_CONFIG: begin
                    wait_drained();
                    set_config(DIRECTED_CFG[cfg_next]);
                    cfg_next++;
                end
                default: begin
                    wait_drained();
                    write_reg(REG_SPARE, 16'hFFFF);
                    cfg_valid <= 1'b0;
                end
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            no_idle = 1'b0;
            case (ph)
                0: cfg = '{8'd1, 16'd8, 16'd4};
                1: cfg = '{8'd3, 16'd12, 16'd6};
                2: cfg = '{8'd0, 16'd5, 16'd3};
                3: cfg = '{8'($urandom_range(1, 6)), 16'($urandom_range(2, 20)),
                           16'($urandom_range(1, 12))};
                default: cfg = '{8'd2, 16'd1, 16'd1};
            endcase
            set_config(cfg);
            d = cfg.debounce_ticks;
            l = cfg.long_press_ticks;
            g = cfg.double_gap_ticks;
            if (ph == 1) hold_req = 1'b1;
            if (ph == 2) no_idle = 1'b1;
            for (int k = 0; k < PHASE_TICKS; k++) begin
                if (ph == 3 && k == PHASE_TICKS / 2) wait_drained();
                for (int b = 0; b < 2; b++) begin
                    if (goal_left[b] == 0) begin
                        goal_down[b] = !goal_down[b];
                        if (goal_down[b])
                            goal_left[b] = ($urandom_range(0, 2) == 0) ?
                                           $urandom_range(d + l, d + l + 3) :
                                           $urandom_range(1, d + l);
                        else
                            goal_left[b] = ($urandom_range(0, 2) == 0) ?
                                           $urandom_range(d + g, d + g + 3) :
                                           $urandom_range(1, d + g);
                    end
                    goal_left[b]--;
                    pins[b] = !goal_down[b];
                    if ($urandom_range(0, 99) < 6) pins[b] = !pins[b];
                end
                drive_tick(pins, UNTYPED, NO_EVENT, NO_EVENT);
            end
        end

        wait_drained();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

>>> button_click_long_double_detect.f
+incdir+src
src/bcld_pkg.sv
src/bcld_lane.sv
src/bcld_merge.sv
src/button_click_long_double_detect.sv
bench/tb_button_click_long_double_detect.sv
